@@ hdl/slfr_pkg.sv @@
`default_nettype none
package slfr_pkg;

   localparam int MaxPayload    = 32;
   localparam int PayIdxW       = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
   localparam int RdCntW        = $clog2(MaxPayload + 1);
   localparam int CntW          = 7;
   localparam int SyncBytes     = 4;
   localparam int HeaderBytes   = 7;
   localparam int FrameOverhead = 9;

   localparam logic [31:0] SyncReset = 32'h2083_B8ED;

   typedef enum logic [2:0] {
      STAT_TAKEN    = 3'd0,
      STAT_RESYNC   = 3'd1,
      STAT_DONE     = 3'd2,
      STAT_ERR_DROP = 3'd3,
      STAT_OVERSIZE = 3'd4
   } slfr_status_type;

   typedef struct packed {
      logic               en;
      logic [PayIdxW-1:0] addr;
      logic [7:0]         data;
   } slfr_wr_type;

   typedef struct packed {
      slfr_status_type status;
      logic            dump;
      logic            done_empty;
   } slfr_evt_type;

endpackage
`default_nettype wire

@@ hdl/slfr_ram.sv @@
`default_nettype none
module slfr_ram (
   input  wire logic                       clock,
   input  wire slfr_pkg::slfr_wr_type      wr,
   input  wire logic [slfr_pkg::PayIdxW-1:0] rd_addr,
   output logic [7:0]                      rd_data
);
   import slfr_pkg::*;

   logic [7:0] mem [0:MaxPayload-1];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ hdl/slfr_parser.sv @@
`default_nettype none
module slfr_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            rx_byte,
   input  wire logic                  line_error,
   input  wire logic                  csr_wr_en,
   input  wire logic [31:0]           csr_wr_data,
   output slfr_pkg::slfr_evt_type     evt,
   output slfr_pkg::slfr_wr_type      wr,
   output logic [7:0]                 addr_reg,
   output logic [7:0]                 code_reg,
   output logic [7:0]                 len_reg
);
   import slfr_pkg::*;

   logic [31:0]     sync_ff, sync_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [7:0]      addr_ff, addr_in;
   logic [7:0]      code_ff, code_in;
   logic [7:0]      len_ff, len_in;
   logic [7:0]      sync_cur;
   logic [CntW-1:0] pos;
   logic [7:0]      next_cnt;
   logic            frame_end;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    sync_cur = sync_ff[31:24];
         2'd1:    sync_cur = sync_ff[23:16];
         2'd2:    sync_cur = sync_ff[15:8];
         default: sync_cur = sync_ff[7:0];
      endcase
   end

   assign pos       = cnt_ff - CntW'(HeaderBytes);
   assign next_cnt  = {1'b0, cnt_ff} + 8'd1;
   assign frame_end = {1'b0, next_cnt} >= ({1'b0, len_ff} + 9'(FrameOverhead));

   always_comb begin
      sync_in         = csr_wr_en ? csr_wr_data : sync_ff;
      cnt_in          = cnt_ff;
      addr_in         = addr_ff;
      code_in         = code_ff;
      len_in          = len_ff;
      evt.status      = STAT_TAKEN;
      evt.dump        = 1'b0;
      evt.done_empty  = 1'b0;
      wr.en           = 1'b0;
      wr.addr         = pos[PayIdxW-1:0];
      wr.data         = rx_byte;
      if (accept) begin
         priority if (line_error) begin
            evt.status = STAT_ERR_DROP;
         end else if (cnt_ff < CntW'(SyncBytes)) begin
            if (rx_byte == sync_cur) begin
               cnt_in = cnt_ff + CntW'(1);
            end else begin
               evt.status = STAT_RESYNC;
               cnt_in     = (rx_byte == sync_ff[31:24]) ? CntW'(1) : CntW'(0);
            end
         end else if (cnt_ff == CntW'(4)) begin
            addr_in = rx_byte;
            cnt_in  = CntW'(5);
         end else if (cnt_ff == CntW'(5)) begin
            code_in = rx_byte;
            cnt_in  = CntW'(6);
         end else if (cnt_ff == CntW'(6)) begin
            len_in = rx_byte;
            if (rx_byte > 8'(MaxPayload)) begin
               evt.status = STAT_OVERSIZE;
               cnt_in     = '0;
            end else begin
               cnt_in = CntW'(HeaderBytes);
            end
         end else if (len_ff > 8'(MaxPayload)) begin
            evt.status = STAT_OVERSIZE;
            cnt_in     = '0;
         end else begin
            wr.en = ({1'b0, pos} < len_ff);
            if (!frame_end) begin
               cnt_in = next_cnt[CntW-1:0];
            end else begin
               cnt_in     = '0;
               evt.status = STAT_DONE;
               if (len_ff == 8'd0) begin
                  evt.done_empty = 1'b1;
               end else begin
                  evt.dump = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SyncReset;
         cnt_ff  <= '0;
         addr_ff <= '0;
         code_ff <= '0;
         len_ff  <= '0;
      end else begin
         sync_ff <= sync_in;
         cnt_ff  <= cnt_in;
         addr_ff <= addr_in;
         code_ff <= code_in;
         len_ff  <= len_in;
      end
   end

   assign addr_reg = addr_ff;
   assign code_reg = code_ff;
   assign len_reg  = len_ff;

endmodule
`default_nettype wire

@@ hdl/sync_length_frame_receiver.sv @@
// Sync-word, length-prefixed frame receiver. A received byte is taken only while no replay
// runs and the result register is free, and yields one status transfer, but the last byte
// of a frame with a payload starts a replay instead; a byte with a line error is dropped without
// touching the frame state. A completed frame replays its payload from the 32-entry store,
// each byte by a registered memory read, then a load of the result register once free; new
// input is held off meanwhile. A frame with an empty payload yields a single transfer.
`default_nettype none
module sync_length_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_line_error,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_frame_address,
   output logic [7:0]       rsp_frame_code,
   output logic [7:0]       rsp_payload_length,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_payload_valid,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);
   import slfr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [RdCntW-1:0] rd_idx_ff, rd_idx_in;
   logic              out_valid_ff, out_valid_in;
   slfr_status_type   out_status_ff, out_status_in;
   logic [7:0]        out_addr_ff, out_addr_in;
   logic [7:0]        out_code_ff, out_code_in;
   logic [7:0]        out_len_ff, out_len_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_pvalid_ff, out_pvalid_in;
   logic              out_last_ff, out_last_in;

   logic         out_free;
   logic         accept;
   logic         rd_last;
   slfr_evt_type evt;
   slfr_wr_type  wr;
   logic [7:0]   addr_reg, code_reg, len_reg;
   logic [7:0]   rd_data;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rd_last   = (8'(rd_idx_ff) + 8'd1) == len_reg;

   slfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .line_error  (req_line_error),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .evt         (evt),
      .wr          (wr),
      .addr_reg    (addr_reg),
      .code_reg    (code_reg),
      .len_reg     (len_reg)
   );

   slfr_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_idx_ff[PayIdxW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_addr_in   = out_addr_ff;
      out_code_in   = out_code_ff;
      out_len_in    = out_len_ff;
      out_byte_in   = out_byte_ff;
      out_pvalid_in = out_pvalid_ff;
      out_last_in   = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (evt.dump) begin
                  state_in  = ST_READ;
                  rd_idx_in = '0;
               end else begin
                  out_valid_in  = 1'b1;
                  out_status_in = evt.status;
                  out_addr_in   = evt.done_empty ? addr_reg : 8'd0;
                  out_code_in   = evt.done_empty ? code_reg : 8'd0;
                  out_len_in    = 8'd0;
                  out_byte_in   = 8'd0;
                  out_pvalid_in = 1'b0;
                  out_last_in   = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = STAT_DONE;
               out_addr_in   = addr_reg;
               out_code_in   = code_reg;
               out_len_in    = len_reg;
               out_byte_in   = rd_data;
               out_pvalid_in = 1'b1;
               out_last_in   = rd_last;
               if (rd_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in  = ST_READ;
                  rd_idx_in = rd_idx_ff + RdCntW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      out_status_ff <= out_status_in;
      out_addr_ff   <= out_addr_in;
      out_code_ff   <= out_code_in;
      out_len_ff    <= out_len_in;
      out_byte_ff   <= out_byte_in;
      out_pvalid_ff <= out_pvalid_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_frame_address  = out_addr_ff;
   assign rsp_frame_code     = out_code_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_payload_valid  = out_pvalid_ff;
   assign rsp_last           = out_last_ff;

endmodule
`default_nettype wire

@@ hdl/slfr_chk.sv @@
`default_nettype none
module slfr_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_status,
   input wire logic [7:0]  rsp_payload_length,
   input wire logic [7:0]  rsp_payload_byte,
   input wire logic        rsp_payload_valid,
   input wire logic        rsp_last
);
   import slfr_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_last)
                                 && $stable(rsp_status))
      else $error("stalled result changed");

   a_pvalid_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> rsp_status == STAT_DONE)
      else $error("payload byte outside a completed frame");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_DONE |-> rsp_last && !rsp_payload_valid
                                              && rsp_payload_length == 8'd0)
      else $error("status result not single");

   a_burst_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid && !rsp_last |-> req_stall)
      else $error("input taken during payload replay");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sync_length_frame_receiver slfr_chk u_slfr_chk (.*);
`default_nettype wire
